// File: src/pal_pkg.sv
// Shared types and constants for the polyline arc-length texture coordinate block.
`default_nettype none
package pal_pkg;

  localparam int COORD_W        = 16;  // vertex coordinate width
  localparam int U_W            = 16;  // Q0.16 texture coordinate
  localparam int CUM_W          = 32;  // Q24.8 running length
  localparam int ROOT_FRAC_SH   = 16;  // squared length scaled by 2^16 gives Q.8 root
  localparam int SUMSQ_W        = 2 * COORD_W + 1;
  localparam int RAD_W          = 50;  // even width holding sum of squares << 16
  localparam int ROOT_W         = RAD_W / 2;
  localparam int QUO_W          = U_W + 1;
  localparam int MAX_POINTS_DEF = 64;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic                      last_point;
  } vertex_t;

  typedef struct packed {
    logic [U_W-1:0] u_coord;
    logic           v_coord;
    logic           last_result;
    logic           overflowed;
  } tex_t;

endpackage
`default_nettype wire

// File: src/pal_if.sv
// Valid/ready channel interfaces for vertex items and texture coordinate items.
`default_nettype none
interface pal_vertex_if;
  logic             valid;
  logic             ready;
  pal_pkg::vertex_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface pal_tex_if;
  logic          valid;
  logic          ready;
  pal_pkg::tex_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface
`default_nettype wire

// File: src/pal_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: src/pal_sqrt.sv
// Bit-serial integer square root, one root bit per cycle, rounded down.
`default_nettype none
module pal_sqrt (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [pal_pkg::RAD_W-1:0]   radicand,
  output      logic                        done,
  output      logic [pal_pkg::ROOT_W-1:0]  root
);

  localparam int CNT_W = $clog2(pal_pkg::ROOT_W);

  logic [pal_pkg::RAD_W-1:0]  rad;
  logic [pal_pkg::ROOT_W:0]   rem;
  logic [CNT_W-1:0]           cnt;
  logic                       busy;

  logic [pal_pkg::ROOT_W+2:0] rem_sh;
  logic [pal_pkg::ROOT_W+2:0] trial;
  logic [pal_pkg::ROOT_W+2:0] diff;
  logic                       ge;

  // two radicand bits enter the partial remainder each step
  assign rem_sh = {rem, rad[pal_pkg::RAD_W-1 -: 2]};
  assign trial  = {1'b0, root, 2'b01};
  assign ge     = rem_sh >= trial;
  assign diff   = rem_sh - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(pal_pkg::ROOT_W - 1);
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        rad  <= {rad[pal_pkg::RAD_W-3:0], 2'b00};
        rem  <= ge ? diff[pal_pkg::ROOT_W:0] : rem_sh[pal_pkg::ROOT_W:0];
        root <= {root[pal_pkg::ROOT_W-2:0], ge};
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: src/pal_div.sv
// Bit-serial restoring divider for cum * 2^16 / total, given cum <= total.
`default_nettype none
module pal_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [pal_pkg::CUM_W-1:0]  dividend,
  input  wire logic [pal_pkg::CUM_W-1:0]  divisor,
  output      logic                       done,
  output      logic [pal_pkg::QUO_W-1:0]  quo
);

  localparam int CNT_W = $clog2(pal_pkg::QUO_W);

  logic [pal_pkg::CUM_W:0]   rem;
  logic [pal_pkg::CUM_W-1:0] dv;
  logic                      first;
  logic [CNT_W-1:0]          cnt;
  logic                      busy;

  logic [pal_pkg::CUM_W:0]   cur;
  logic [pal_pkg::CUM_W:0]   diff;
  logic                      ge;

  // first step tests the integer bit without shifting
  assign cur  = first ? rem : {rem[pal_pkg::CUM_W-1:0], 1'b0};
  assign ge   = cur >= {1'b0, dv};
  assign diff = cur - {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      cnt   <= '0;
      first <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        first <= 1'b1;
        cnt   <= CNT_W'(pal_pkg::QUO_W - 1);
        rem   <= {1'b0, dividend};
        dv    <= divisor;
        quo   <= '0;
      end else if (busy) begin
        first <= 1'b0;
        rem   <= ge ? diff : cur;
        quo   <= {quo[pal_pkg::QUO_W-2:0], ge};
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: src/polyline_arc_length_texcoord.sv
// Top level: polyline arc-length accumulation and texture coordinate emission.
//
// Channels: vertex (sink) takes one polyline vertex per item: signed x/y and
// a last flag. texcoord (source) gives one item per stored vertex, in order,
// once the vertex marked last has been taken: u = cumulative/total in Q0.16
// (saturated at 65535, 0 for a zero-length polyline), v = index mod 2, a last
// flag and a sticky overflow flag for vertices dropped beyond MAX_POINTS.
// Vertex steps: accept, decode, squaring of dx and then dy on the shared
// 16x16 multiplier, a start step, the bit-serial square root and a commit
// step. The first vertex and a dropped one need only accept and decode.
// vertex.ready is high only in the idle state.
// Emission: per result a RAM read, a divider start, the serial divider and
// its done step, then an output load. Results go through an output register,
// so a new vertex is taken while the final item still waits.
// If texcoord stalls, the sequencer holds before loading the next item.
// Reset (rst, synchronous): clears the sequencer, counts, flags and output
// valid. The length RAM is not cleared; entries are always written first.
`default_nettype none
module polyline_arc_length_texcoord #(
  parameter int MAX_POINTS = pal_pkg::MAX_POINTS_DEF
) (
  input wire logic   clk,
  input wire logic   rst,
  pal_vertex_if.sink   vertex,
  pal_tex_if.source    texcoord
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_SQX, S_SQY, S_SQ_GO, S_ROOT,
    S_EM_RD, S_EM_GO, S_EM_DIV, S_EM_OUT
  } state_t;

  state_t state;

  // latched vertex
  logic signed [pal_pkg::COORD_W-1:0] x_reg, y_reg;
  logic                               last_reg;
  // polyline state
  logic signed [pal_pkg::COORD_W-1:0] prev_x, prev_y;
  logic [CNT_W-1:0]                   count;
  logic                               overflow_flag;
  logic [pal_pkg::CUM_W-1:0]          cum_last;   // running total
  logic [IDX_W-1:0]                   k;          // emit index
  logic [pal_pkg::SUMSQ_W-1:0]        acc;        // dx^2 + dy^2
  // output register
  logic                               tex_valid;
  pal_pkg::tex_t                      tex_item;

  // --- segment difference and squaring ---
  logic signed [pal_pkg::COORD_W:0] dx_s, dy_s;
  logic [pal_pkg::COORD_W-1:0]      dx, dy, mul_a;
  logic [2*pal_pkg::COORD_W-1:0]    prod;

  assign dx_s  = {x_reg[pal_pkg::COORD_W-1], x_reg} - {prev_x[pal_pkg::COORD_W-1], prev_x};
  assign dy_s  = {y_reg[pal_pkg::COORD_W-1], y_reg} - {prev_y[pal_pkg::COORD_W-1], prev_y};
  assign dx    = dx_s[pal_pkg::COORD_W] ? pal_pkg::COORD_W'(-dx_s) : dx_s[pal_pkg::COORD_W-1:0];
  assign dy    = dy_s[pal_pkg::COORD_W] ? pal_pkg::COORD_W'(-dy_s) : dy_s[pal_pkg::COORD_W-1:0];
  assign mul_a = (state == S_SQX) ? dx : dy;
  assign prod  = mul_a * mul_a;

  // --- square root: length in Q.8 = isqrt(sumsq << 16) ---
  logic                          sq_start, sq_done;
  logic [pal_pkg::RAD_W-1:0]     radicand;
  logic [pal_pkg::ROOT_W-1:0]    seg;

  assign sq_start = (state == S_SQ_GO);
  assign radicand = {(pal_pkg::RAD_W - pal_pkg::SUMSQ_W - pal_pkg::ROOT_FRAC_SH)'(0),
                     acc, pal_pkg::ROOT_FRAC_SH'(0)};

  pal_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (radicand),
    .done     (sq_done),
    .root     (seg)
  );

  // saturating accumulate
  logic [pal_pkg::CUM_W:0]   sum_w;
  logic [pal_pkg::CUM_W-1:0] sum_sat;

  assign sum_w   = {1'b0, cum_last} + (pal_pkg::CUM_W + 1)'(seg);
  assign sum_sat = sum_w[pal_pkg::CUM_W] ? '1 : sum_w[pal_pkg::CUM_W-1:0];

  // --- length store ---
  logic                      ram_we;
  logic [IDX_W-1:0]          ram_waddr;
  logic [pal_pkg::CUM_W-1:0] ram_wdata, ram_rdata;

  assign ram_we    = ((state == S_DECIDE) && (count == '0)) || ((state == S_ROOT) && sq_done);
  assign ram_waddr = count[IDX_W-1:0];
  assign ram_wdata = (state == S_ROOT) ? sum_sat : '0;

  pal_ram #(
    .WIDTH (pal_pkg::CUM_W),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (k),
    .rdata (ram_rdata)
  );

  // --- normalising divide ---
  logic                      dv_start, dv_done;
  logic [pal_pkg::QUO_W-1:0] quo;

  assign dv_start = (state == S_EM_GO);

  pal_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (dv_start),
    .dividend (ram_rdata),
    .divisor  (cum_last),
    .done     (dv_done),
    .quo      (quo)
  );

  logic [pal_pkg::U_W-1:0] u_val;
  logic                    k_last;
  logic                    out_free;
  logic                    out_load;

  // zero total gives u = 0; a quotient of one saturates
  assign u_val    = (cum_last == '0)        ? '0 :
                    quo[pal_pkg::QUO_W-1]   ? '1 : quo[pal_pkg::U_W-1:0];
  assign k_last   = ((CNT_W'(k) + 1'b1) == count);
  assign out_free = !tex_valid || texcoord.ready;
  assign out_load = (state == S_EM_OUT) && out_free;

  assign vertex.ready   = (state == S_IDLE);
  assign texcoord.valid = tex_valid;
  assign texcoord.item  = tex_item;

  // --- sequencer ---
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      overflow_flag <= 1'b0;
      prev_x        <= '0;
      prev_y        <= '0;
      k             <= '0;
      tex_valid     <= 1'b0;
    end else begin
      // a load in this cycle sets valid again below
      if (texcoord.ready && !out_load) begin
        tex_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          k <= '0;
          if (vertex.valid) begin
            x_reg    <= vertex.item.x_coord;
            y_reg    <= vertex.item.y_coord;
            last_reg <= vertex.item.last_point;
            state    <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (count == '0) begin
            // first vertex: length zero
            cum_last <= '0;
            prev_x   <= x_reg;
            prev_y   <= y_reg;
            count    <= CNT_W'(1);
            state    <= last_reg ? S_EM_RD : S_IDLE;
          end else if (count < CNT_MAX) begin
            state <= S_SQX;
          end else begin
            overflow_flag <= 1'b1;
            state         <= last_reg ? S_EM_RD : S_IDLE;
          end
        end
        S_SQX: begin
          acc   <= pal_pkg::SUMSQ_W'(prod);
          state <= S_SQY;
        end
        S_SQY: begin
          acc   <= acc + pal_pkg::SUMSQ_W'(prod);
          state <= S_SQ_GO;
        end
        S_SQ_GO: begin
          state <= S_ROOT;
        end
        S_ROOT: begin
          if (sq_done) begin
            cum_last <= sum_sat;
            prev_x   <= x_reg;
            prev_y   <= y_reg;
            count    <= count + 1'b1;
            state    <= last_reg ? S_EM_RD : S_IDLE;
          end
        end
        S_EM_RD: begin
          state <= S_EM_GO;   // RAM read issued; data lands in S_EM_GO
        end
        S_EM_GO: begin
          state <= S_EM_DIV;
        end
        S_EM_DIV: begin
          if (dv_done) begin
            state <= S_EM_OUT;
          end
        end
        S_EM_OUT: begin
          if (out_free) begin
            tex_valid            <= 1'b1;
            tex_item.u_coord     <= u_val;
            tex_item.v_coord     <= k[0];
            tex_item.last_result <= k_last;
            tex_item.overflowed  <= overflow_flag;
            if (k_last) begin
              count         <= '0;
              overflow_flag <= 1'b0;
              prev_x        <= '0;
              prev_y        <= '0;
              state         <= S_IDLE;
            end else begin
              k     <= k + 1'b1;
              state <= S_EM_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // --- assertions ---
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_MAX)
    else $error("stored vertex count beyond capacity");

  a_emit_index: assert property (@(posedge clk) disable iff (rst)
    (state == S_EM_RD || state == S_EM_GO || state == S_EM_DIV || state == S_EM_OUT)
      |-> (CNT_W'(k) < count))
    else $error("emit index past stored vertices");

  a_root_in_place: assert property (@(posedge clk) disable iff (rst)
    sq_done |-> (state == S_ROOT))
    else $error("square root finished outside its wait state");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (out_load && k_last) |=> (count == '0 && !overflow_flag && tex_valid))
    else $error("polyline state not cleared after final item");

endmodule
`default_nettype wire
